[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the free-block bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // default sizing of the bitmap
    localparam int BBA_MAX_BLOCKS = 4096;
    localparam int BBA_WORD_BITS  = 32;

    // fixed field widths
    localparam int BN_W = 12;   // block number
    localparam int CNT_W = 13;  // block count, free count, used total
    localparam int OP_W = 2;
    localparam int STAT_W = 2;

    // packed stream widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    // reset value of the block count register
    localparam logic [CNT_W-1:0] BBA_COUNT_RESET = 13'd4096;

    // request codes
    localparam logic [OP_W-1:0] OP_TEST = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_MUL,
        S_DIV_SUB,
        S_DIV_FIX,
        S_UPDATE,
        S_SCAN,
        S_DONE
    } bba_state_t;

endpackage

[rtl/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/block_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// Keeps one used/free bit per block in a RAM of WORD_BITS-bit words, all free
// after reset, plus a count of used blocks. A request tests a block, marks a
// block used or free, or finds the lowest free block below the configured
// block count; every request returns one result beat with a status and the
// current free count. After reset the block clears the bitmap RAM one word
// per cycle and accepts no request meanwhile; block count register writes
// are taken at any time. One request is worked on at a time. A test or mark
// steps through a word/bit split of the block number in DIV_MUL, DIV_SUB and
// DIV_FIX, the last of which issues the RAM read, a read-modify-write in
// UPDATE, a load of the result register in DONE and a return to idle; an
// out-of-range test or mark goes from DIV_MUL straight to DONE. A find reads
// the bitmap RAM through its single read port one word per cycle until it
// meets a free block or runs past the block count. A finished result waits in
// an output register, so a new request can be accepted while the previous
// result is still stalled; only a second result waits for it.
// ----------------------------------------------------------------------------
module block_bitmap_allocator import bba_pkg::*; #(
    parameter int MAX_BLOCKS = BBA_MAX_BLOCKS,
    parameter int WORD_BITS  = BBA_WORD_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration: volume block count
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    // request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // block_number[11:0], mark_value[12], zero
    input  logic [OP_W-1:0]     s_tuser,   // operation[1:0]
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // is_used[0], found_block[12:1],
                                           // free_count[25:13], zero
    output logic [STAT_W-1:0]   m_tuser    // status[1:0]
);

    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int RM_W = BIT_W + 1;
    // reciprocal split of the block number into word and bit
    localparam int DIV_SH = BN_W + 8;
    localparam int PROD_W = BN_W + DIV_SH;
    localparam int DIV_M = (1 << DIV_SH) / WORD_BITS;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] MAX_CLIP =
        CNT_W'((MAX_BLOCKS > CNT_MAX) ? CNT_MAX : MAX_BLOCKS);
    localparam logic [CNT_W-1:0] WB_CNT = CNT_W'(WORD_BITS);
    localparam int USED_MAX = (MAX_BLOCKS < (1 << BN_W)) ? MAX_BLOCKS : (1 << BN_W);
    localparam int PAD_W = M_DATA_W - (1 + BN_W + CNT_W);

    bba_state_t state_reg, state_next;

    logic [CNT_W-1:0]  vol_blocks_reg;
    logic [CNT_W-1:0]  used_total_reg, used_total_next;
    logic [WA_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]  chk_left_reg, chk_left_next;
    logic [CNT_W-1:0]  chk_base_reg, chk_base_next;

    logic [OP_W-1:0]   op_reg;
    logic [BN_W-1:0]   blk_reg;
    logic              mark_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [BN_W-1:0]   quo_reg, quo_next;
    logic [RM_W-1:0]   rem_reg, rem_next;
    logic [WA_W-1:0]   word_reg, word_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic              res_used_reg, res_used_next;
    logic [BN_W-1:0]   res_found_reg, res_found_next;

    logic              m_tvalid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_used_reg;
    logic [BN_W-1:0]   out_found_reg;
    logic [CNT_W-1:0]  out_free_reg;

    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  free_now;
    logic              s_accept;
    logic              out_load;
    logic [BN_W-1:0]   rem_full;
    logic [BN_W-1:0]   fix_quo;
    logic [BIT_W-1:0]  fix_bit;

    logic              ram_we;
    logic [WA_W-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WA_W-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [WORD_BITS-1:0] free_vec;
    logic              free_any;
    logic [BIT_W-1:0]  free_idx;
    logic [CNT_W-1:0]  found_sum;
    logic              cur_bit;
    logic [WORD_BITS-1:0] upd_word;

    // bitmap storage
    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS),
        .ADDR_W(WA_W)
    ) u_bitmap (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // effective count and free count
    assign eff_count = (vol_blocks_reg > MAX_CLIP) ? MAX_CLIP : vol_blocks_reg;
    assign free_now = (eff_count > used_total_reg) ? (eff_count - used_total_reg) : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // word/bit split: correction step of the reciprocal divide
    assign rem_full = blk_reg - BN_W'(quo_next * BN_W'(WORD_BITS));
    always_comb begin
        if (rem_reg >= RM_W'(WORD_BITS)) begin
            fix_quo = quo_reg + 1'b1;
            fix_bit = BIT_W'(rem_reg - RM_W'(WORD_BITS));
        end else begin
            fix_quo = quo_reg;
            fix_bit = rem_reg[BIT_W-1:0];
        end
    end

    // lowest free bit of the word under check, limited to valid blocks
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            free_vec[b] = !ram_rdata[b] && (CNT_W'(b) < chk_left_reg);
        end
        free_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                free_idx = BIT_W'(b);
            end
        end
    end
    assign free_any = |free_vec;
    assign found_sum = chk_base_reg + CNT_W'(free_idx);

    // read-modify-write of the addressed word
    assign cur_bit = ram_rdata[bit_reg];
    always_comb begin
        upd_word = ram_rdata;
        upd_word[bit_reg] = mark_reg;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        used_total_next = used_total_reg;
        ptr_next        = ptr_reg;
        base_next       = base_reg;
        left_next       = left_reg;
        chk_vld_next    = 1'b0;
        chk_left_next   = chk_left_reg;
        chk_base_next   = chk_base_reg;
        prod_next       = prod_reg;
        quo_next        = prod_reg[DIV_SH +: BN_W];
        rem_next        = rem_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        res_status_next = res_status_reg;
        res_used_next   = res_used_reg;
        res_found_next  = res_found_reg;
        ram_we          = 1'b0;
        ram_waddr       = word_reg;
        ram_wdata       = upd_word;
        ram_raddr       = ptr_reg;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = '0;
                if (ptr_reg == WA_W'(NUM_WORDS - 1)) begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_DIV_MUL;
                end
            end
            S_DIV_MUL: begin
                prod_next       = PROD_W'(blk_reg) * PROD_W'(DIV_M);
                res_status_next = STAT_OK;
                res_used_next   = 1'b0;
                res_found_next  = '0;
                unique case (op_reg)
                    OP_TEST, OP_MARK: begin
                        if (CNT_W'(blk_reg) >= eff_count) begin
                            res_status_next = STAT_RANGE;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_DIV_SUB;
                        end
                    end
                    OP_FIND: begin
                        ptr_next   = '0;
                        base_next  = '0;
                        left_next  = eff_count;
                        state_next = S_SCAN;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DIV_SUB: begin
                rem_next   = RM_W'(rem_full);
                state_next = S_DIV_FIX;
            end
            S_DIV_FIX: begin
                word_next  = WA_W'(fix_quo);
                bit_next   = fix_bit;
                ram_raddr  = WA_W'(fix_quo);
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                if (op_reg == OP_MARK) begin
                    ram_we = 1'b1;
                    if (mark_reg && !cur_bit) begin
                        used_total_next = used_total_reg + 1'b1;
                    end else if (!mark_reg && cur_bit && (used_total_reg != '0)) begin
                        used_total_next = used_total_reg - 1'b1;
                    end
                end else begin
                    res_used_next = cur_bit;
                end
                state_next = S_DONE;
            end
            S_SCAN: begin
                // issue the next word read
                if (left_reg != '0) begin
                    chk_vld_next  = 1'b1;
                    chk_left_next = left_reg;
                    chk_base_next = base_reg;
                    ptr_next      = ptr_reg + 1'b1;
                    base_next     = base_reg + WB_CNT;
                    left_next     = (left_reg > WB_CNT) ? (left_reg - WB_CNT) : '0;
                end
                // check the word read last cycle
                if (chk_vld_reg && free_any) begin
                    res_found_next = found_sum[BN_W-1:0];
                    chk_vld_next   = 1'b0;
                    state_next     = S_DONE;
                end else if (!chk_vld_reg && (left_reg == '0)) begin
                    res_status_next = STAT_FULL;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            ptr_reg         <= '0;
            chk_vld_reg     <= 1'b0;
            used_total_reg  <= '0;
            vol_blocks_reg  <= BBA_COUNT_RESET;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            chk_vld_reg    <= chk_vld_next;
            used_total_reg <= used_total_next;
            if (cfg_wr_en) begin
                vol_blocks_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= s_tuser;
            blk_reg  <= s_tdata[BN_W-1:0];
            mark_reg <= s_tdata[BN_W];
        end
        base_reg       <= base_next;
        left_reg       <= left_next;
        chk_left_reg   <= chk_left_next;
        chk_base_reg   <= chk_base_next;
        prod_reg       <= prod_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_used_reg   <= res_used_next;
        res_found_reg  <= res_found_next;
        if (out_load) begin
            out_status_reg <= res_status_reg;
            out_used_reg   <= res_used_reg;
            out_found_reg  <= res_found_reg;
            out_free_reg   <= free_now;
        end
    end

    // result beat
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_free_reg, out_found_reg, out_used_reg};

`ifndef SYNTHESIS
    // one request at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("request accepted while one is in progress");

    // used count never exceeds the blocks that can be marked
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_total_reg <= CNT_W'(USED_MAX))
        else $error("used block count out of range");

    // the used flag is only reported with an ok status
    a_used_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tuser == STAT_OK))
        else $error("used flag set on a failed request");

    // bitmap writes outside the clear pass come only from a mark
    a_write_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && (state_reg != S_CLEAR)) |-> (op_reg == OP_MARK))
        else $error("bitmap written by a request that is not a mark");
`endif

endmodule
